FILE: sv/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Sample and phase widths, the step limits, the request types of both
// channels and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;

	// Phase is unsigned with five integer bits (enough for 16.0 plus one step).
	localparam int PH_W   = FRAC_BITS + 5;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

	localparam logic [PH_W-1:0] PH_ONE   = PH_W'(1) << FRAC_BITS;
	localparam logic [PH_W-1:0] PH_TWO   = PH_W'(2) << FRAC_BITS;
	localparam logic [PH_W-1:0] STEP_MIN = PH_ONE >> 4;
	localparam logic [PH_W-1:0] STEP_MAX = PH_ONE << 4;
	localparam logic [PH_W-1:0] STEP_RST = PH_ONE;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_sample;
		logic                          buffer_last;
	} smp_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          run_end;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INTERP,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic load;   // take the accepted input sample
		logic issue;  // start one result and advance the phase
		logic hold;   // the issued result is the held sample
		logic wrap;   // close the interval: phase minus one, current becomes previous
		logic clear;  // end of buffer: clear the phase and the held sample, keep the step
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic phase_lt_one;
		logic last;
		logic advance;
	} status_t;

endpackage

FILE: sv/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl: sequencer of the linear interpolation resampler
// Accepts one input request at a time and steps the datapath through the
// interpolated results of the interval and the held results at buffer end.
// ----------------------------------------------------------------------------
module lir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	input  logic                smp_last,
	output logic                smp_stall,
	input  lir_pkg::status_t    st,
	output lir_pkg::cmd_t       cmd
);

	lir_pkg::state_t state_q;
	lir_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lir_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		smp_stall = 1'b1;
		case (state_q)
			lir_pkg::ST_IDLE: begin
				smp_stall = 1'b0;
				if (smp_valid) begin
					cmd.load = 1'b1;
					if (st.have_prev) begin
						state_nxt = lir_pkg::ST_INTERP;
					end else if (smp_last) begin
						state_nxt = lir_pkg::ST_HOLD;
					end
				end
			end
			lir_pkg::ST_INTERP: begin
				if (st.phase_lt_one) begin
					cmd.issue = st.advance;
				end else begin
					cmd.wrap  = 1'b1;
					state_nxt = st.last ? lir_pkg::ST_HOLD : lir_pkg::ST_IDLE;
				end
			end
			lir_pkg::ST_HOLD: begin
				if (st.phase_lt_one) begin
					cmd.issue = st.advance;
					cmd.hold  = 1'b1;
				end else begin
					cmd.clear = 1'b1;
					state_nxt = lir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lir_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/lir_dp.sv
// ----------------------------------------------------------------------------
// lir_dp: datapath of the linear interpolation resampler
// Holds the previous sample, the output phase and the step register, and runs
// a multiply stage and an output register that the result stall holds.
// ----------------------------------------------------------------------------
module lir_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lir_pkg::smp_t                   smp,
	input  logic                            cfg_we,
	input  logic [lir_pkg::PH_W-1:0]        cfg_data,
	input  lir_pkg::cmd_t                   cmd,
	output lir_pkg::status_t                st,
	output logic                            res_valid,
	input  logic                            res_stall,
	output lir_pkg::res_t                   res
);

	logic [lir_pkg::PH_W-1:0]                 step_q;
	logic [lir_pkg::PH_W-1:0]                 step_eff;
	logic [lir_pkg::PH_W-1:0]                 phase_q;
	logic [lir_pkg::PH_W-1:0]                 phase_nxt;
	logic signed [lir_pkg::SAMPLE_BITS-1:0]   prev_q;
	logic signed [lir_pkg::SAMPLE_BITS-1:0]   cur_q;
	logic signed [lir_pkg::DIFF_W-1:0]        diff_q;
	logic                                     have_prev_q;
	logic                                     last_q;
	logic signed [lir_pkg::PROD_W-1:0]        prod;
	logic                                     end_now;
	logic                                     advance;

	logic                                     valid_s1;
	logic signed [lir_pkg::SAMPLE_BITS-1:0]   base_s1;
	logic signed [lir_pkg::DIFF_W-1:0]        prod_s1;
	logic                                     end_s1;

	logic                                     res_valid_q;
	lir_pkg::res_t                            res_q;
	logic signed [lir_pkg::DIFF_W-1:0]        sum;

	always_comb begin
		if (step_q < lir_pkg::STEP_MIN) begin
			step_eff = lir_pkg::STEP_MIN;
		end else if (step_q > lir_pkg::STEP_MAX) begin
			step_eff = lir_pkg::STEP_MAX;
		end else begin
			step_eff = step_q;
		end
	end

	// The phase is below one whenever a result is issued, so the sum stays in range.
	assign phase_nxt = phase_q + step_eff;

	// At buffer end the held results follow, so the interval's last result only
	// closes the run when no held position is left.
	always_comb begin
		if (cmd.hold) begin
			end_now = (phase_nxt >= lir_pkg::PH_ONE);
		end else begin
			end_now = (phase_nxt >= lir_pkg::PH_ONE) &&
				(!last_q || (phase_nxt >= lir_pkg::PH_TWO));
		end
	end

	assign prod = lir_pkg::PROD_W'(diff_q) *
		lir_pkg::PROD_W'($signed({1'b0, phase_q[lir_pkg::FRAC_BITS-1:0]}));

	assign advance = !res_valid_q || !res_stall;

	assign st.have_prev    = have_prev_q;
	assign st.phase_lt_one = (phase_q < lir_pkg::PH_ONE);
	assign st.last         = last_q;
	assign st.advance      = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= lir_pkg::STEP_RST;
			phase_q     <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_data;
			end
			if (cmd.load && !have_prev_q) begin
				prev_q      <= smp.in_sample;
				have_prev_q <= 1'b1;
			end
			if (cmd.clear) begin
				phase_q     <= '0;
				prev_q      <= '0;
				have_prev_q <= 1'b0;
			end else if (cmd.wrap) begin
				phase_q     <= phase_q - lir_pkg::PH_ONE;
				prev_q      <= cur_q;
				have_prev_q <= 1'b1;
			end else if (cmd.issue) begin
				phase_q <= phase_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= smp.in_sample;
			diff_q <= lir_pkg::DIFF_W'(smp.in_sample) - lir_pkg::DIFF_W'(prev_q);
			last_q <= smp.buffer_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd.issue;
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			end_s1 <= end_now;
			if (cmd.hold) begin
				base_s1 <= cur_q;
				prod_s1 <= '0;
			end else begin
				base_s1 <= prev_q;
				// Dropping the fraction bits of a signed product floors it.
				prod_s1 <= prod[lir_pkg::FRAC_BITS +: lir_pkg::DIFF_W];
			end
			res_q.out_sample <= sum[lir_pkg::SAMPLE_BITS-1:0];
			res_q.run_end    <= end_s1;
		end
	end

	assign sum = lir_pkg::DIFF_W'(base_s1) + prod_s1;

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: sv/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: streaming linear interpolation rate converter
// Takes a current sample and the held previous one and emits every output
// position of the interval, advancing a fixed-point phase by the step.
// ----------------------------------------------------------------------------
// Pipeline: each issued result passes the multiply stage, then the output register.
// Throughput: a request is taken in the idle state, then one result per cycle
//   comes from the shared multiplier while results are taken; a wrap step closes
//   the interval, and at buffer end a clear step follows the held results.
// Reset: asynchronous, clears the phase, the held sample and the step to 1.0.
module linear_interp_resampler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         smp_valid,
	output logic                         smp_stall,
	input  lir_pkg::smp_t                smp,
	output logic                         res_valid,
	input  logic                         res_stall,
	output lir_pkg::res_t                res,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lir_pkg::PH_W-1:0]     cfg_data
);

	lir_pkg::cmd_t    cmd;
	lir_pkg::status_t st;

	assign cfg_ready = 1'b1;

	lir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_last  (smp.buffer_last),
		.smp_stall (smp_stall),
		.st        (st),
		.cmd       (cmd)
	);

	lir_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
